FILE: rtl/rrd_pkg.sv
package rrd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // reject reasons
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_STATUS    = 3'd2;
  localparam logic [2:0] ERR_TRUNC_LEN = 3'd3;
  localparam logic [2:0] ERR_FIELD_SZ  = 3'd4;
  localparam logic [2:0] ERR_PAYLOAD   = 3'd5;

  localparam logic [31:0] MAX_FIELD_RESET = 32'd67108864;

  // command queue between parser and result stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] record_bytes;
  } rrd_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field_index;
    logic [7:0] payload_byte;
    logic       success_flag;
    logic [2:0] fail_code;
    logic       last_result;
  } rrd_result_t;

  // one command per input byte that causes results: optional payload, optional verdict
  typedef struct packed {
    logic       has_data;
    logic [1:0] data_field;
    logic [7:0] data_byte;
    logic       has_verdict;
    logic       accept;
    logic       success;
    logic [2:0] err;
  } rrd_cmd_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
    logic              not_empty;
  } rrd_qstat_t;

  // record magic, byte by position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h4D;
      3'd1:    b = 8'h44;
      3'd2:    b = 8'h52;
      3'd3:    b = 8'h45;
      3'd4:    b = 8'h53;
      3'd5:    b = 8'h30;
      3'd6:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/rrd_front.sv
module rrd_front
  import rrd_pkg::*;
#(
  parameter int RECORD_LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  rrd_item_t item,
  input  logic      cfg_valid,
  input  logic [31:0] cfg_data,
  output logic      cmd_wr,
  output rrd_cmd_t  cmd
);

  localparam int LB = (RECORD_LENGTH_BITS < 32) ? RECORD_LENGTH_BITS : 32;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_MAGIC  = 6'b000010,
    PH_STATUS = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [LB-1:0] bytes_left, bytes_left_next;
  logic [3:0]  sub_count, sub_count_next;
  logic [31:0] len_lo, len_lo_next;
  logic        len_hi, len_hi_next;
  logic [31:0] field_left, field_left_next;
  logic [1:0]  current_field, current_field_next;
  logic        status_seen, status_seen_next;
  logic        first_empty, first_empty_next;
  logic [31:0] max_field_bytes;

  logic          accept_in;
  logic [7:0]    byte_in;
  logic [LB-1:0] total;
  logic [32:0]   size;
  logic          do_reject, do_fdone, do_begin, bl_zero;
  logic [2:0]    rej_code;
  logic [31:0]   field_dec;

  assign accept_in = push && !full;
  assign byte_in   = item.data_byte;
  assign total     = item.record_bytes[LB-1:0];

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    sub_count_next     = sub_count;
    len_lo_next        = len_lo;
    len_hi_next        = len_hi;
    field_left_next    = field_left;
    current_field_next = current_field;
    status_seen_next   = status_seen;
    first_empty_next   = first_empty;
    cmd                = '0;
    do_reject          = 1'b0;
    do_fdone           = 1'b0;
    do_begin           = 1'b0;
    rej_code           = ERR_NONE;
    size               = '0;
    field_dec          = field_left - 32'd1;

    // count down the record outside the first byte
    if (phase != PH_START && bytes_left != '0) begin
      bytes_left_next = bytes_left - LB'(1);
    end
    // bytes left after this byte is zero
    bl_zero = (phase == PH_START) ? (total <= LB'(1)) : (bytes_left < LB'(2));

    unique case (phase)
      PH_START: begin
        bytes_left_next    = (total != '0) ? total - LB'(1) : '0;
        current_field_next = 2'd0;
        first_empty_next   = 1'b0;
        status_seen_next   = 1'b0;
        if (total < LB'(9) || byte_in != magic_byte(3'd0)) begin
          do_reject = 1'b1;
          rej_code  = ERR_HEADER;
        end else begin
          phase_next     = PH_MAGIC;
          sub_count_next = 4'd1;
        end
      end
      PH_MAGIC: begin
        if (byte_in != magic_byte(sub_count[2:0])) begin
          do_reject = 1'b1;
          rej_code  = ERR_HEADER;
        end else begin
          sub_count_next = sub_count + 4'd1;
          if (sub_count == 4'd7) phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (byte_in > 8'd1) begin
          do_reject = 1'b1;
          rej_code  = ERR_STATUS;
        end else begin
          status_seen_next = byte_in[0];
          do_begin         = 1'b1;
        end
      end
      PH_LEN: begin
        // shift in big-endian, keep a sticky flag for anything above 32 bits
        len_lo_next    = {len_lo[23:0], byte_in};
        len_hi_next    = len_hi | (len_lo[31:24] != 8'd0);
        sub_count_next = sub_count + 4'd1;
        size           = {len_hi_next, len_lo_next};
        if (sub_count == 4'd7) begin
          if (size > {1'b0, max_field_bytes} ||
              ((bytes_left == '0) ? (size != 33'd0) : (size >= 33'(bytes_left)))) begin
            do_reject = 1'b1;
            rej_code  = ERR_FIELD_SZ;
          end else begin
            if (current_field == 2'd0) first_empty_next = (size == 33'd0);
            if (size == 33'd0) begin
              do_fdone = 1'b1;
            end else begin
              field_left_next = len_lo_next;
              phase_next      = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        cmd.has_data    = 1'b1;
        cmd.data_field  = current_field;
        cmd.data_byte   = byte_in;
        field_left_next = field_dec;
        if (field_dec == 32'd0) do_fdone = 1'b1;
      end
      PH_SKIP: begin
        if (bytes_left < LB'(2)) phase_next = PH_START;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    // close a field: next length, or the record verdict
    if (do_fdone) begin
      if (current_field < 2'd2) begin
        current_field_next = current_field + 2'd1;
        do_begin           = 1'b1;
      end else if (first_empty || !bl_zero) begin
        do_reject = 1'b1;
        rej_code  = ERR_PAYLOAD;
      end else begin
        phase_next      = PH_START;
        cmd.has_verdict = 1'b1;
        cmd.accept      = 1'b1;
        cmd.success     = status_seen;
      end
    end

    // start a length, failing when fewer than eight bytes remain
    if (do_begin) begin
      if (bytes_left < LB'(9)) begin
        do_reject = 1'b1;
        rej_code  = ERR_TRUNC_LEN;
      end else begin
        phase_next     = PH_LEN;
        sub_count_next = 4'd0;
        len_lo_next    = '0;
        len_hi_next    = 1'b0;
      end
    end

    if (do_reject) begin
      cmd.has_verdict = 1'b1;
      cmd.accept      = 1'b0;
      cmd.err         = rej_code;
      phase_next      = bl_zero ? PH_START : PH_SKIP;
    end
  end

  assign cmd_wr = accept_in && (cmd.has_data || cmd.has_verdict);

  // advance parser state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      bytes_left      <= '0;
      sub_count       <= '0;
      len_lo          <= '0;
      len_hi          <= 1'b0;
      field_left      <= '0;
      current_field   <= '0;
      status_seen     <= 1'b0;
      first_empty     <= 1'b0;
      max_field_bytes <= MAX_FIELD_RESET;
    end else begin
      if (accept_in) begin
        phase         <= phase_next;
        bytes_left    <= bytes_left_next;
        sub_count     <= sub_count_next;
        len_lo        <= len_lo_next;
        len_hi        <= len_hi_next;
        field_left    <= field_left_next;
        current_field <= current_field_next;
        status_seen   <= status_seen_next;
        first_empty   <= first_empty_next;
      end
      if (cfg_valid) max_field_bytes <= cfg_data;
    end
  end

endmodule

FILE: rtl/rrd_queue.sv
module rrd_queue
  import rrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  rrd_cmd_t   wr_cmd,
  input  logic       rd,
  output rrd_cmd_t   head,
  output rrd_qstat_t stat
);

  rrd_cmd_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QLVL_W-1:0] level;

  assign head           = slots[rd_ptr];
  assign stat.level     = level;
  assign stat.full      = (level == QLVL_W'(QDEPTH));
  assign stat.not_empty = (level != '0);

  // store commands
  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_cmd;
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({wr, rd})
        2'b10:   level <= level + QLVL_W'(1);
        2'b01:   level <= level - QLVL_W'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

FILE: rtl/rrd_back.sv
module rrd_back
  import rrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rrd_cmd_t    head,
  input  logic        q_not_empty,
  output logic        cmd_rd,
  input  logic        pop,
  output logic        empty,
  output rrd_result_t result
);

  rrd_result_t first_res, second_res, out_res, pend_res;
  logic        two_res, out_valid, pend_valid;

  // expand one command into one or two result beats
  always_comb begin
    second_res              = '0;
    second_res.kind         = head.accept ? KIND_ACCEPT : KIND_REJECT;
    second_res.success_flag = head.accept ? head.success : 1'b0;
    second_res.fail_code    = head.accept ? ERR_NONE : head.err;
    second_res.last_result  = 1'b1;
    two_res                 = head.has_data && head.has_verdict;
    if (head.has_data) begin
      first_res              = '0;
      first_res.kind         = KIND_PAYLOAD;
      first_res.field_index  = head.data_field;
      first_res.payload_byte = head.data_byte;
      first_res.last_result  = !head.has_verdict;
    end else begin
      first_res = second_res;
    end
  end

  assign cmd_rd = q_not_empty && !pend_valid && (!out_valid || pop);
  assign empty  = !out_valid;
  assign result = out_res;

  // load the output register, hold the verdict of a two-beat command behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd_rd) begin
      out_valid  <= 1'b1;
      out_res    <= first_res;
      pend_valid <= two_res;
      pend_res   <= second_res;
    end else if (out_valid && pop) begin
      if (pend_valid) begin
        out_res    <= pend_res;
        pend_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/result_record_deframer.sv
// Channel   Handshake            Payload        Beat taken when
// item      push / full          rrd_item_t     push & !full
// result    pop / empty          rrd_result_t   pop & !empty
// cfg       cfg_valid/cfg_ready  cfg_data[31:0] cfg_valid & cfg_ready
//
// One input byte is taken per cycle while the command queue (4 deep) has room.
// A result passes the command queue and then the output register to reach the
// ports; a byte ending a field with the verdict gives a payload, then the verdict.
// full rises only when the result side stalls long enough to fill the queue.
// rst is synchronous: parser back to record start, queue and outputs empty,
// max_field_bytes back to 64 MiB. cfg_ready is always high.
module result_record_deframer
  import rrd_pkg::*;
#(
  parameter int RECORD_LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  rrd_item_t   item,
  output logic        empty,
  input  logic        pop,
  output rrd_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic       cmd_wr, cmd_rd;
  rrd_cmd_t   cmd, head;
  rrd_qstat_t qstat;

  assign full      = qstat.full;
  assign cfg_ready = 1'b1;

  // parse and classify bytes
  rrd_front #(
    .RECORD_LENGTH_BITS(RECORD_LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (qstat.full),
    .item     (item),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd)
  );

  // decouple parser from result stage
  rrd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_wr),
    .wr_cmd(cmd),
    .rd    (cmd_rd),
    .head  (head),
    .stat  (qstat)
  );

  // present result beats
  rrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_not_empty(qstat.not_empty),
    .cmd_rd     (cmd_rd),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  // a verdict always closes the results of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != KIND_PAYLOAD) |-> result.last_result)
    else $error("verdict result not marked last");

  // an accept carries no error code
  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_ACCEPT) |-> (result.fail_code == ERR_NONE))
    else $error("accept result with error code");

  // never write a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> !qstat.full)
    else $error("command queue overflow");

  // a read only from a non-empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_rd |-> qstat.not_empty)
    else $error("command queue underflow");

endmodule

FILE: test/record_result_checker.sv
`timescale 1ns / 100ps
module record_result_checker
  import rrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  rrd_item_t   item,
  input  logic        empty,
  input  logic        pop,
  input  rrd_result_t result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          awaited_count,
  output int          error_count
);

  // "MDRES01" and a zero byte, first byte in the top octet
  localparam logic [63:0] RECORD_MAGIC = 64'h4D44_5245_5330_3100;

  typedef enum logic [5:0] {
    REC_START  = 6'b000001,
    REC_MAGIC  = 6'b000010,
    REC_STATUS = 6'b000100,
    REC_LENGTH = 6'b001000,
    REC_DATA   = 6'b010000,
    REC_SKIP   = 6'b100000
  } parse_phase_t;

  // parser state as the block should hold it
  parse_phase_t phase;
  logic [31:0]  max_field;
  logic [31:0]  bytes_left;
  logic [3:0]   byte_pos;     // position in magic or in a length word
  logic [63:0]  length_acc;
  logic [31:0]  field_left;
  logic [1:0]   field_no;
  logic         status_bit;
  logic         first_empty;

  rrd_result_t  awaited_results[$];
  rrd_result_t  step_results[$];
  rrd_result_t  oldest;

  function automatic rrd_result_t make_result(input logic [1:0] kind,
                                              input logic [1:0] fidx,
                                              input logic [7:0] data,
                                              input logic       succ,
                                              input logic [2:0] err);
    rrd_result_t r;
    r.kind         = kind;
    r.field_index  = fidx;
    r.payload_byte = data;
    r.success_flag = succ;
    r.fail_code    = err;
    r.last_result  = 1'b0;
    return r;
  endfunction

  // give up on the record; skip whatever it still holds
  task automatic reject_record(input logic [2:0] code);
    step_results.insert(step_results.size(),
                        make_result(KIND_REJECT, 2'd0, 8'd0, 1'b0, code));
    phase = (bytes_left == 0) ? REC_START : REC_SKIP;
  endtask

  // a length word needs eight more bytes in the record
  task automatic open_length();
    if (bytes_left < 8) begin
      reject_record(ERR_TRUNC_LEN);
    end else begin
      phase      = REC_LENGTH;
      byte_pos   = 4'd0;
      length_acc = 64'd0;
    end
  endtask

  task automatic close_field();
    if (field_no < 2) begin
      field_no = field_no + 2'd1;
      open_length();
    end else if (first_empty || bytes_left != 0) begin
      reject_record(ERR_PAYLOAD);
    end else begin
      phase = REC_START;
      step_results.insert(step_results.size(),
                          make_result(KIND_ACCEPT, 2'd0, 8'd0, status_bit, ERR_NONE));
    end
  endtask

  // advance the parser by one byte and queue what it should emit
  task automatic parse_record_byte(input rrd_item_t it);
    logic [7:0]  b;
    logic [31:0] total;
    rrd_result_t r;
    int          n;
    b     = it.data_byte;
    total = it.record_bytes;
    step_results.delete();
    if (phase != REC_START && bytes_left != 0) bytes_left = bytes_left - 32'd1;
    case (phase)
      REC_START: begin
        bytes_left  = (total != 0) ? total - 32'd1 : 32'd0;
        field_no    = 2'd0;
        first_empty = 1'b0;
        status_bit  = 1'b0;
        if (total < 9 || b != RECORD_MAGIC[63 -: 8]) begin
          reject_record(ERR_HEADER);
        end else begin
          phase    = REC_MAGIC;
          byte_pos = 4'd1;
        end
      end
      REC_MAGIC: begin
        if (b != RECORD_MAGIC[63 - 8 * int'(byte_pos[2:0]) -: 8]) begin
          reject_record(ERR_HEADER);
        end else begin
          byte_pos = byte_pos + 4'd1;
          if (byte_pos >= 8) phase = REC_STATUS;
        end
      end
      REC_STATUS: begin
        if (b > 1) begin
          reject_record(ERR_STATUS);
        end else begin
          status_bit = b[0];
          open_length();
        end
      end
      REC_LENGTH: begin
        length_acc = {length_acc[55:0], b};
        byte_pos   = byte_pos + 4'd1;
        if (byte_pos >= 8) begin
          if (length_acc > {32'd0, max_field} || length_acc > {32'd0, bytes_left}) begin
            reject_record(ERR_FIELD_SZ);
          end else begin
            if (field_no == 0) first_empty = (length_acc == 64'd0);
            if (length_acc == 64'd0) begin
              close_field();
            end else begin
              field_left = length_acc[31:0];
              phase      = REC_DATA;
            end
          end
        end
      end
      REC_DATA: begin
        step_results.insert(step_results.size(),
                            make_result(KIND_PAYLOAD, field_no, b, 1'b0, ERR_NONE));
        if (field_left != 0) field_left = field_left - 32'd1;
        if (field_left == 0) close_field();
      end
      REC_SKIP: begin
        if (bytes_left == 0) phase = REC_START;
      end
      default: begin
        phase = REC_START;
      end
    endcase
    // mark the final result of this byte
    n = step_results.size();
    for (int i = 0; i < n; i++) begin
      r             = step_results[i];
      r.last_result = (i == n - 1);
      awaited_results.insert(awaited_results.size(), r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // compare results leaving the block first, then take the new byte in
  always @(posedge clk) begin
    if (rst) begin
      phase       = REC_START;
      max_field   = MAX_FIELD_RESET;
      bytes_left  = 32'd0;
      byte_pos    = 4'd0;
      length_acc  = 64'd0;
      field_left  = 32'd0;
      field_no    = 2'd0;
      status_bit  = 1'b0;
      first_empty = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_field = cfg_data;
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("result kind %0d arrived with nothing awaited", result.kind);
          error_count++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("kind", oldest.kind, result.kind);
          check_field("field_index", oldest.field_index, result.field_index);
          check_field("payload_byte", oldest.payload_byte, result.payload_byte);
          check_field("success_flag", oldest.success_flag, result.success_flag);
          check_field("fail_code", oldest.fail_code, result.fail_code);
          check_field("last_result", oldest.last_result, result.last_result);
        end
      end
      if (push && !full) parse_record_byte(item);
    end
    awaited_count <= awaited_results.size();
  end

endmodule

FILE: test/tb_result_record_deframer.sv
`timescale 1ns / 100ps
module tb_result_record_deframer;
  import rrd_pkg::*;

  localparam int          ITEM_TARGET    = 550;
  localparam int          PHASES         = 4;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          FLOOD_HOLD     = 48;
  localparam logic [63:0] RECORD_MAGIC   = 64'h4D44_5245_5330_3100;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  rrd_item_t   item;
  logic        empty;
  logic        pop;
  rrd_result_t result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          awaited_count;
  int          error_count;

  logic [7:0]  frame_q[$];
  int          bytes_sent     = 0;
  bit          sender_eager   = 1'b0;
  int          flood_requests = 0;
  int          floods_done    = 0;

  result_record_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  record_result_checker results_chk (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .awaited_count (awaited_count),
    .error_count   (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one beat and hold it until the block takes it
  task automatic offer_byte(input logic [7:0] b, input logic [31:0] total);
    int gap;
    gap = sender_eager ? 0 : idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, total};
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // send a record of the given length; the length rides only on the first beat,
  // later beats carry noise there. A record too long to send stops where the
  // frame ends, as the block never gets past its reject.
  task automatic send_record(input logic [31:0] total);
    int         count;
    logic [7:0] b;
    count = (total == 0) ? 1 : (total > 1000) ? frame_q.size() : int'(total);
    for (int i = 0; i < count; i++) begin
      b = (i < frame_q.size()) ? frame_q[i] : 8'($urandom);
      offer_byte(b, (i == 0) ? total : $urandom);
    end
  endtask

  task automatic patch_length(input int pos, input logic [63:0] len);
    for (int k = 0; k < 8; k++) frame_q[pos + k] = len[63 - 8 * k -: 8];
  endtask

  // build a well-formed record with random payload
  task automatic frame_record(input int l0, input int l1, input int l2,
                              input logic [7:0] status);
    int sizes[3];
    sizes[0] = l0;
    sizes[1] = l1;
    sizes[2] = l2;
    frame_q.delete();
    for (int k = 0; k < 8; k++) frame_q.push_back(RECORD_MAGIC[63 - 8 * k -: 8]);
    frame_q.push_back(status);
    for (int f = 0; f < 3; f++) begin
      repeat (8) frame_q.push_back(8'd0);
      patch_length(frame_q.size() - 8, 64'(sizes[f]));
      repeat (sizes[f]) frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_max_field(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every awaited result drain
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly good records, the rest damaged in one place
  task automatic random_record();
    int          l0;
    int          l1;
    int          l2;
    int          pick;
    int          k;
    int          which;
    logic [31:0] total;
    logic [63:0] lv;
    l0 = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    l1 = $urandom_range(0, 4);
    l2 = $urandom_range(0, 4);
    frame_record(l0, l1, l2, 8'($urandom_range(0, 1)));
    total = frame_q.size();
    pick  = $urandom_range(0, 99);
    if (pick >= 96) begin
      total = $urandom_range(0, 8);
    end else if (pick >= 91) begin
      which = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0:       lv = {$urandom, $urandom};
        1:       lv = {32'd0, $urandom};
        default: lv = 64'($urandom_range(0, 8));
      endcase
      patch_length(9 + 8 * which + ((which > 0) ? l0 : 0) + ((which > 1) ? l1 : 0), lv);
    end else if (pick >= 86) begin
      frame_q[8] = 8'($urandom_range(2, 255));
    end else if (pick >= 79) begin
      k          = $urandom_range(0, 7);
      frame_q[k] = frame_q[k] ^ (8'd1 << $urandom_range(0, 7));
    end else if (pick >= 71) begin
      total = $urandom_range(9, frame_q.size() - 1);
    end else if (pick >= 62) begin
      total = total + $urandom_range(1, 4);
    end
    send_record(total);
  endtask

  task automatic run_directed();
    // zero length, then a record too short for its magic and status
    frame_record(2, 1, 1, 8'h00);
    send_record(32'd0);
    send_record(32'd8);
    // magic broken at its last byte, then bad status values
    frame_record(1, 1, 1, 8'h01);
    frame_q[7] = 8'h01;
    send_record(32'd9);
    frame_q[7] = 8'h00;
    frame_q[8] = 8'h02;
    send_record(32'd9);
    frame_q[8] = 8'hFF;
    send_record(32'd10);
    // no room for the first length word
    frame_record(2, 1, 1, 8'h01);
    send_record(32'd12);
    // field larger than what is left of the record
    frame_record(4, 0, 0, 8'h00);
    send_record(32'd20);
    // field length with every bit set
    frame_record(3, 0, 0, 8'h01);
    patch_length(9, 64'hFFFF_FFFF_FFFF_FFFF);
    send_record(32'd17);
    // empty task identifier, then trailing bytes
    frame_record(0, 2, 1, 8'h01);
    send_record(frame_q.size());
    frame_record(2, 1, 1, 8'h00);
    send_record(frame_q.size() + 3);
    // clean records: verdict with the last payload byte, and at a length byte
    frame_record(3, 2, 4, 8'h01);
    frame_q[17] = 8'h00;
    frame_q[18] = 8'hFF;
    send_record(frame_q.size());
    frame_record(1, 0, 0, 8'h00);
    send_record(frame_q.size());
    // length word cut short after the first field
    frame_record(2, 1, 1, 8'h01);
    send_record(32'd26);
    settle();
    // tight limit: one over it, then exactly at it
    write_max_field(32'd2);
    frame_record(3, 1, 1, 8'h01);
    send_record(frame_q.size());
    frame_record(2, 2, 2, 8'h00);
    send_record(frame_q.size());
    settle();
  endtask

  // result side: stretches fully open, mostly open or half open, and a long hold for each flood
  initial begin
    int open_pct;
    int stall;
    int span;
    span     = 0;
    open_pct = 100;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (span == 0) begin
        span = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       open_pct = 100;
          1:       open_pct = 85;
          default: open_pct = 50;
        endcase
      end
      span--;
      stall = 0;
      if (floods_done != flood_requests) begin
        floods_done++;
        pop  <= 1'b0;
        stall = FLOOD_HOLD;
      end else if ($urandom_range(0, 99) < open_pct) begin
        pop <= 1'b1;
      end else begin
        pop  <= 1'b0;
        stall = idle_cycles();
      end
      @(posedge clk);
      repeat (stall) @(posedge clk);
    end
  end

  // end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] limits[PHASES];
    int          quota;
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    limits[0] = MAX_FIELD_RESET;
    limits[1] = $urandom_range(1, 6);
    limits[2] = 32'd0;
    limits[3] = 32'hFFFF_FFFF;
    for (int p = 0; p < PHASES; p++) begin
      write_max_field(limits[p]);
      // share what is left of the item budget among the remaining phases
      quota = bytes_sent;
      if (bytes_sent < ITEM_TARGET) quota = bytes_sent + (ITEM_TARGET - bytes_sent) / (PHASES - p);
      // flood the block while the result side holds off
      if (p == 0 || p == PHASES - 1) begin
        sender_eager = 1'b1;
        flood_requests++;
        frame_record(8, 2, 2, 8'($urandom_range(0, 1)));
        send_record(frame_q.size());
      end
      while (bytes_sent < quota) begin
        sender_eager = ($urandom_range(0, 3) == 0);
        random_record();
      end
      sender_eager = 1'b0;
      settle();
    end

    // longest record length: second field over what is left, then skip for good
    frame_record(2, 3, 1, 8'h01);
    patch_length(19, 64'h0000_0000_FFFF_FFFE);
    send_record(32'hFFFF_FFFF);
    settle();

    if (error_count == 0 && awaited_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
